/* sv/rsg_pkg.sv */
// Shared types and constants of the linear resampler with gain.
package rsg_pkg;

    // Input beat: one audio sample and the end-of-utterance flag.
    typedef struct packed {
        logic signed [15:0] in_sample;
        logic               in_last;
    } in_beat_t;

    // Output beat: one resampled sample, the end mark and the empty flag.
    typedef struct packed {
        logic signed [15:0] out_sample;
        logic               out_last;
        logic               out_empty;
    } out_beat_t;

    // One classified input item as it travels from the front to the back.
    typedef struct packed {
        logic signed [15:0] prev_sample;
        logic signed [15:0] cur_sample;
        logic               first;
        logic               last;
    } job_t;

    // Register map.
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic        REG_STEP   = 1'b0;
    localparam logic        REG_GAIN   = 1'b1;

    // Register widths and reset values.
    localparam int unsigned STEP_W     = 21;
    localparam int unsigned GAIN_W     = 16;
    localparam logic [STEP_W-1:0] STEP_RESET = 21'd90317;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

    // Phase arithmetic in Q5.16 (21 bits, 16 of them fraction).
    localparam logic [STEP_W-1:0] ONE_Q16  = 21'd65536;
    localparam logic [STEP_W-1:0] TWO_Q16  = 21'd131072;
    localparam logic [STEP_W-1:0] STEP_MIN = 21'd4096;
    localparam logic [STEP_W-1:0] STEP_MAX = 21'd1048576;

    // Saturation limits of a 16-bit sample.
    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

endpackage

/* sv/rsg_front.sv */
// Front end: accepts input beats and tags each one with its predecessor.
module rsg_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rsg_pkg::in_beat_t s_payload,
    output logic              push_valid,
    input  logic              push_ready,
    output rsg_pkg::job_t     push_job
);

    logic signed [15:0] prev_reg, prev_next;
    logic               have_prev_reg, have_prev_next;
    logic               take;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign take       = s_valid & push_ready;

    // Classify the beat: the first of an utterance has no predecessor.
    always_comb begin
        push_job.prev_sample = prev_reg;
        push_job.cur_sample  = s_payload.in_sample;
        push_job.first       = ~have_prev_reg;
        push_job.last        = s_payload.in_last;
    end

    // Remember the sample; a last beat closes the utterance.
    always_comb begin
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        if (take) begin
            prev_next      = s_payload.in_sample;
            have_prev_next = ~s_payload.in_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
        end else begin
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
        end
    end

endmodule

/* sv/rsg_queue.sv */
// Short job queue between the front end and the back end.
module rsg_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  rsg_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output rsg_pkg::job_t pop_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rsg_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // Pointer and fill count update, wrapping at any depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* sv/rsg_back.sv */
// Back end: phase sequencer, interpolation and gain pipeline, output register.
module rsg_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [rsg_pkg::STEP_W-1:0]   step_q16,
    input  logic [rsg_pkg::GAIN_W-1:0]   gain_q8,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  rsg_pkg::job_t                pop_job,
    output logic                         m_valid,
    input  logic                         m_ready,
    output rsg_pkg::out_beat_t           m_payload
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_INTERP = 3'b010,
        ST_TAIL   = 3'b100
    } seq_state_t;

    localparam int unsigned SW = rsg_pkg::STEP_W;

    // Sequencer state.
    seq_state_t         state_reg, state_next;
    logic [SW-1:0]      phase_reg, phase_next;
    logic signed [15:0] a_reg, a_next;
    logic signed [16:0] diff_reg, diff_next;
    logic signed [15:0] cur_reg, cur_next;
    logic               last_reg, last_next;
    logic               emitted_reg, emitted_next;

    // Issue stage.
    logic               iss_valid_reg, iss_valid_next;
    logic signed [15:0] iss_a_reg, iss_a_next;
    logic signed [16:0] iss_diff_reg, iss_diff_next;
    logic [15:0]        iss_frac_reg, iss_frac_next;
    logic               iss_last_reg, iss_last_next;
    logic               iss_empty_reg, iss_empty_next;

    // Stage 1: slope product.
    logic               p1_valid_reg;
    logic signed [15:0] p1_a_reg;
    logic signed [33:0] p1_prod_reg;
    logic               p1_last_reg, p1_empty_reg;

    // Stage 2: interpolated sample.
    logic               p2_valid_reg;
    logic signed [15:0] p2_x_reg;
    logic               p2_last_reg, p2_empty_reg;

    // Stage 3: gain product.
    logic               p3_valid_reg;
    logic signed [32:0] p3_prod_reg;
    logic               p3_last_reg, p3_empty_reg;

    // Output register.
    logic               m_valid_reg;
    rsg_pkg::out_beat_t m_payload_reg;

    logic               adv;
    logic [SW-1:0]      step_eff;
    logic [SW-1:0]      phase_sum;
    logic               below_one;
    logic signed [33:0] num;
    logic signed [15:0] interp_x;
    logic signed [24:0] gained_q;
    logic signed [15:0] sat_x;
    rsg_pkg::out_beat_t out_next;

    // The whole pipeline moves when the output register can take a beat.
    assign adv       = ~m_valid_reg | m_ready;
    assign pop_ready = adv & (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Clamp the step to its supported range.
    always_comb begin
        priority if (step_q16 < rsg_pkg::STEP_MIN) begin
            step_eff = rsg_pkg::STEP_MIN;
        end else if (step_q16 > rsg_pkg::STEP_MAX) begin
            step_eff = rsg_pkg::STEP_MAX;
        end else begin
            step_eff = step_q16;
        end
    end

    assign phase_sum = phase_reg + step_eff;
    assign below_one = (phase_reg < rsg_pkg::ONE_Q16);

    // Sequencer: at most one result issued per advancing cycle; a new item is taken only when idle.
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        a_next         = a_reg;
        diff_next      = diff_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        emitted_next   = emitted_reg;
        iss_valid_next = 1'b0;
        iss_a_next     = a_reg;
        iss_diff_next  = diff_reg;
        iss_frac_next  = phase_reg[15:0];
        iss_last_next  = 1'b0;
        iss_empty_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    a_next       = pop_job.prev_sample;
                    diff_next    = 17'(pop_job.cur_sample) - 17'(pop_job.prev_sample);
                    cur_next     = pop_job.cur_sample;
                    last_next    = pop_job.last;
                    emitted_next = 1'b0;
                    if (pop_job.first) begin
                        phase_next = '0;
                        state_next = pop_job.last ? ST_TAIL : ST_IDLE;
                    end else begin
                        state_next = ST_INTERP;
                    end
                end
            end
            ST_INTERP: begin
                if (below_one) begin
                    // Interpolate between the previous and the current sample.
                    iss_valid_next = 1'b1;
                    iss_last_next  = last_reg & (phase_sum >= rsg_pkg::TWO_Q16);
                    emitted_next   = 1'b1;
                    phase_next     = phase_sum;
                end else begin
                    phase_next = phase_reg - rsg_pkg::ONE_Q16;
                    state_next = last_reg ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL: begin
                iss_a_next    = cur_reg;
                iss_diff_next = '0;
                iss_frac_next = '0;
                if (below_one) begin
                    // Positions on the final index repeat the last sample.
                    iss_valid_next = 1'b1;
                    iss_last_next  = (phase_sum >= rsg_pkg::ONE_Q16);
                    emitted_next   = 1'b1;
                    phase_next     = phase_sum;
                end else begin
                    // Nothing was emitted for this item: send the end marker alone.
                    iss_valid_next = ~emitted_reg;
                    iss_last_next  = 1'b1;
                    iss_empty_next = 1'b1;
                    phase_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Interpolation: divide by 65536 truncating toward zero.
    always_comb begin
        num      = {{2{p1_a_reg[15]}}, p1_a_reg, 16'b0} + p1_prod_reg;
        interp_x = num[31:16] + {15'b0, (num[33] & (num[15:0] != '0))};
    end

    // Gain: divide by 256 truncating toward zero, then saturate.
    always_comb begin
        gained_q = p3_prod_reg[32:8] + {24'b0, (p3_prod_reg[32] & (p3_prod_reg[7:0] != '0))};
        priority if (gained_q[24] && !(&gained_q[23:15])) begin
            sat_x = rsg_pkg::SAMPLE_MIN;
        end else if (!gained_q[24] && (|gained_q[23:15])) begin
            sat_x = rsg_pkg::SAMPLE_MAX;
        end else begin
            sat_x = gained_q[15:0];
        end
        out_next.out_sample = p3_empty_reg ? '0 : sat_x;
        out_next.out_last   = p3_last_reg;
        out_next.out_empty  = p3_empty_reg;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            emitted_reg   <= 1'b0;
            iss_valid_reg <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else if (adv) begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            emitted_reg   <= emitted_next;
            iss_valid_reg <= iss_valid_next;
            p1_valid_reg  <= iss_valid_reg;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            m_valid_reg   <= p3_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg         <= a_next;
            diff_reg      <= diff_next;
            cur_reg       <= cur_next;
            last_reg      <= last_next;
            iss_a_reg     <= iss_a_next;
            iss_diff_reg  <= iss_diff_next;
            iss_frac_reg  <= iss_frac_next;
            iss_last_reg  <= iss_last_next;
            iss_empty_reg <= iss_empty_next;
            p1_a_reg      <= iss_a_reg;
            p1_prod_reg   <= iss_diff_reg * $signed({1'b0, iss_frac_reg});
            p1_last_reg   <= iss_last_reg;
            p1_empty_reg  <= iss_empty_reg;
            p2_x_reg      <= interp_x;
            p2_last_reg   <= p1_last_reg;
            p2_empty_reg  <= p1_empty_reg;
            p3_prod_reg   <= p2_x_reg * $signed({1'b0, gain_q8});
            p3_last_reg   <= p2_last_reg;
            p3_empty_reg  <= p2_empty_reg;
            m_payload_reg <= out_next;
        end
    end

    // An empty result is always the end mark and carries a zero sample.
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_payload_reg.out_empty) |->
            (m_payload_reg.out_last && (m_payload_reg.out_sample == '0)))
        else $error("empty result without end mark or with a sample");

    // While interpolating, the phase never grows past one interval plus a step.
    a_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INTERP) |->
            (phase_reg < (rsg_pkg::ONE_Q16 + rsg_pkg::STEP_MAX)))
        else $error("phase out of range during interpolation");

    // A stalled output freezes every stage of the pipeline.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable({iss_valid_reg, p1_valid_reg, p2_valid_reg, p3_valid_reg,
                          state_reg, phase_reg}))
        else $error("pipeline moved during an output stall");

endmodule

/* sv/linear_resampler_with_gain_unit.sv */
// Top level of the linear resampler with gain: register file and block wiring.
//
// Usage: input beats (s_valid/s_ready/s_payload) carry one signed 16-bit
// sample each; in_last marks the final sample of an utterance. Result beats
// (m_valid/m_ready/m_payload) carry resampled samples taken at positions
// i*step_q16 from the first sample, multiplied by gain_q8 and saturated;
// out_last marks the final result, and out_empty marks a lone end marker.
// The APB port writes step_q16 at address 0 and gain_q8 at address 4.
// The first result of an item passes the queue, the sequencer, the issue
// register, three arithmetic stages and the output register.
// Throughput: the sequencer issues one result per cycle while the output
// is not stalled, and takes a new item only after the current one is done.
// Input beats are taken into a QUEUE_DEPTH-entry queue while the back end
// works, so the sender only waits when the queue is full.
// When the receiver stalls, the whole back-end pipeline holds and the
// queue keeps filling. Reset empties the queue and pipeline, restores the
// register defaults and starts a new utterance.
module linear_resampler_with_gain_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  rsg_pkg::in_beat_t                  s_payload,
    output logic                               m_valid,
    input  logic                               m_ready,
    output rsg_pkg::out_beat_t                 m_payload,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rsg_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [rsg_pkg::STEP_W-1:0] step_reg, step_next;
    logic [rsg_pkg::GAIN_W-1:0] gain_reg, gain_next;
    logic                       reg_sel;
    logic                       wr_en;

    logic                       push_valid, push_ready;
    rsg_pkg::job_t              push_job;
    logic                       pop_valid, pop_ready;
    rsg_pkg::job_t              pop_job;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel & penable & pwrite;

    // Register writes.
    always_comb begin
        step_next = step_reg;
        gain_next = gain_reg;
        if (wr_en) begin
            unique case (reg_sel)
                rsg_pkg::REG_STEP: step_next = pwdata[rsg_pkg::STEP_W-1:0];
                rsg_pkg::REG_GAIN: gain_next = pwdata[rsg_pkg::GAIN_W-1:0];
                default:           step_next = step_reg;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (reg_sel)
            rsg_pkg::REG_STEP: prdata = {11'b0, step_reg};
            rsg_pkg::REG_GAIN: prdata = {16'b0, gain_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= rsg_pkg::STEP_RESET;
            gain_reg <= rsg_pkg::GAIN_RESET;
        end else begin
            step_reg <= step_next;
            gain_reg <= gain_next;
        end
    end

    rsg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    rsg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    rsg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_q16  (step_reg),
        .gain_q8   (gain_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

/* verif/tb.sv */
// Self-checking testbench for the linear resampler with gain.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int SAMPLE_GOAL = 160;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_STEP, ROW_GAIN} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [31:0]        value;
        logic               last;
        bit                 fixed;
        rsg_pkg::out_beat_t want;
    } plan_row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    rsg_pkg::in_beat_t              s_payload;
    logic                           m_valid;
    logic                           m_ready;
    rsg_pkg::out_beat_t             m_payload;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [rsg_pkg::APB_ADDR_W-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    // Shadow of the registers and of the interpolation state.
    logic [rsg_pkg::STEP_W-1:0] cfg_step = rsg_pkg::STEP_RESET;
    logic [rsg_pkg::GAIN_W-1:0] cfg_gain = rsg_pkg::GAIN_RESET;
    int                         prev_sample = 0;
    bit                         have_prev = 1'b0;
    int unsigned                phase = 0;

    rsg_pkg::out_beat_t fresh_beats[$];
    rsg_pkg::out_beat_t due_results[$];
    plan_row_t          plan[$];

    int  errors = 0;
    int  samples_in = 0;
    int  results_checked = 0;
    int  writes_done = 0;
    int  cycles = 0;
    bit  idle_on = 1'b1;
    bit  hold_long = 1'b0;
    int  gap_odds = 3;

    linear_resampler_with_gain_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Clock with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int unsigned eff_step();
        if (cfg_step < rsg_pkg::STEP_MIN) return rsg_pkg::STEP_MIN;
        if (cfg_step > rsg_pkg::STEP_MAX) return rsg_pkg::STEP_MAX;
        return cfg_step;
    endfunction

    // Q8.8 gain, truncated toward zero and saturated to 16 bits.
    function automatic logic signed [15:0] gained(input int x);
        longint p;
        p = (longint'(x) * longint'(cfg_gain)) / 256;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return p[15:0];
    endfunction

    // Linear interpolation at a Q16.16 fraction, truncated toward zero.
    function automatic int lerp(input int a, input int b, input int unsigned frac);
        longint num;
        num = longint'(a) * 65536 + longint'(b - a) * longint'(frac);
        return int'(num / 65536);
    endfunction

    // Appends one row to the directed plan.
    function automatic void add_row(input plan_row_t r);
        plan.insert(plan.size(), r);
    endfunction

    // Computes the results of one accepted sample into fresh_beats.
    task automatic resample(input rsg_pkg::in_beat_t b);
        int                 cur;
        int unsigned        st;
        rsg_pkg::out_beat_t r;
        cur = int'($signed(b.in_sample));
        st = eff_step();
        fresh_beats.delete();
        r.out_last = 1'b0;
        r.out_empty = 1'b0;
        if (have_prev) begin
            while (phase < rsg_pkg::ONE_Q16) begin
                r.out_sample = gained(lerp(prev_sample, cur, phase));
                fresh_beats.insert(fresh_beats.size(), r);
                phase += st;
            end
            phase -= rsg_pkg::ONE_Q16;
        end else begin
            phase = 0;
        end
        prev_sample = cur;
        have_prev = 1'b1;
        if (b.in_last) begin
            // Outputs that fall on the final index repeat the final sample.
            while (phase < rsg_pkg::ONE_Q16) begin
                r.out_sample = gained(cur);
                fresh_beats.insert(fresh_beats.size(), r);
                phase += st;
            end
            if (fresh_beats.size() > 0) begin
                fresh_beats[fresh_beats.size() - 1].out_last = 1'b1;
            end else begin
                // Nothing left to emit: a lone end marker.
                r.out_sample = '0;
                r.out_last = 1'b1;
                r.out_empty = 1'b1;
                fresh_beats.insert(fresh_beats.size(), r);
            end
            have_prev = 1'b0;
            phase = 0;
            prev_sample = 0;
        end
        phase &= 32'h001F_FFFF;
    endtask

    // Offers one sample beat and records what it should produce.
    task automatic offer_sample(input rsg_pkg::in_beat_t b, input bit fixed,
                                input rsg_pkg::out_beat_t want);
        if (idle_on && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= b;
        do @(posedge aclk); while (!s_ready);
        resample(b);
        if (fixed) begin
            due_results.insert(due_results.size(), want);
        end else begin
            foreach (fresh_beats[k]) due_results.insert(due_results.size(), fresh_beats[k]);
        end
        samples_in++;
        @(negedge aclk);
    endtask

    // Waits for the block to go idle, then writes one register over APB.
    task automatic set_register(input logic idx, input logic [31:0] val);
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == rsg_pkg::REG_STEP) cfg_step = val[rsg_pkg::STEP_W-1:0];
        else cfg_gain = val[rsg_pkg::GAIN_W-1:0];
        writes_done++;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic plan_row_t smp(input logic signed [15:0] s, input logic l);
        plan_row_t r;
        r.kind = ROW_SAMPLE;
        r.value = {16'h0000, s};
        r.last = l;
        r.fixed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic plan_row_t smp_known(input logic signed [15:0] s, input logic l,
                                            input logic signed [15:0] ws, input logic wl,
                                            input logic we);
        plan_row_t r;
        r = smp(s, l);
        r.fixed = 1'b1;
        r.want.out_sample = ws;
        r.want.out_last = wl;
        r.want.out_empty = we;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input row_kind_t kind, input logic [31:0] v);
        plan_row_t r;
        r = smp('0, 1'b0);
        r.kind = kind;
        r.value = v;
        return r;
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return rsg_pkg::SAMPLE_MAX;
            1: return rsg_pkg::SAMPLE_MIN;
            2: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, rsg_pkg::STEP_MIN - 1);
            1: return $urandom_range(rsg_pkg::STEP_MAX + 1, 21'h1F_FFFF);
            2: return rsg_pkg::STEP_MIN;
            3: return rsg_pkg::STEP_MAX;
            default: return $urandom_range(30000, 200000);
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 16'hFFFF;
            2: return $urandom_range(0, 65535);
            default: return $urandom_range(128, 512);
        endcase
    endfunction

    // Result checker: every accepted beat against the oldest expectation.
    always @(posedge aclk) begin
        rsg_pkg::out_beat_t exp_beat;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result beat: out_sample %0d", m_payload.out_sample);
                errors++;
            end else begin
                exp_beat = due_results.pop_front();
                results_checked++;
                if (m_payload.out_sample !== exp_beat.out_sample) begin
                    $error("out_sample: expected %0d, got %0d",
                           exp_beat.out_sample, m_payload.out_sample);
                    errors++;
                end
                if (m_payload.out_last !== exp_beat.out_last) begin
                    $error("out_last: expected %0b, got %0b",
                           exp_beat.out_last, m_payload.out_last);
                    errors++;
                end
                if (m_payload.out_empty !== exp_beat.out_empty) begin
                    $error("out_empty: expected %0b, got %0b",
                           exp_beat.out_empty, m_payload.out_empty);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stall bursts, calm stretches and one long hold-off.
    initial begin : receiver
        int rx_odds;
        int tick;
        bit held;
        m_ready = 1'b0;
        rx_odds = 4;
        tick = 0;
        held = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            tick++;
            if (tick % 64 == 0) rx_odds = $urandom_range(0, 3);
            if (hold_long && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (idle_on && rx_odds != 0 && $urandom_range(0, rx_odds + 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stimulus: directed plan, then random utterances and register changes.
    initial begin : stimulus
        rsg_pkg::in_beat_t  b;
        rsg_pkg::out_beat_t none;
        int                 len;
        bit                 noise;
        bit                 hold_done;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        none = '0;
        hold_done = 1'b0;

        // Defaults after reset: a lone last sample comes back unchanged.
        add_row(smp_known(16'sd1000, 1'b1, 16'sd1000, 1'b1, 1'b0));
        add_row(smp_known(rsg_pkg::SAMPLE_MAX, 1'b1, rsg_pkg::SAMPLE_MAX, 1'b1, 1'b0));
        add_row(smp_known(rsg_pkg::SAMPLE_MIN, 1'b1, rsg_pkg::SAMPLE_MIN, 1'b1, 1'b0));
        // Largest gain saturates both ways.
        add_row(reg_row(ROW_GAIN, 32'hFFFF));
        add_row(smp_known(rsg_pkg::SAMPLE_MAX, 1'b1, rsg_pkg::SAMPLE_MAX, 1'b1, 1'b0));
        add_row(smp_known(rsg_pkg::SAMPLE_MIN, 1'b1, rsg_pkg::SAMPLE_MIN, 1'b1, 1'b0));
        add_row(smp_known(-16'sd1, 1'b1, -16'sd255, 1'b1, 1'b0));
        // Zero gain silences everything.
        add_row(reg_row(ROW_GAIN, 32'h0));
        add_row(smp_known(16'sd12345, 1'b1, 16'sd0, 1'b1, 1'b0));
        add_row(smp_known(rsg_pkg::SAMPLE_MIN, 1'b1, 16'sd0, 1'b1, 1'b0));
        // Largest step: the final sample has nothing left, so an empty marker.
        add_row(reg_row(ROW_GAIN, 32'd256));
        add_row(reg_row(ROW_STEP, rsg_pkg::STEP_MAX));
        add_row(smp(16'sd100, 1'b0));
        add_row(smp(-16'sd200, 1'b0));
        add_row(smp_known(16'sd300, 1'b1, 16'sd0, 1'b1, 1'b1));
        // Step under range clamps to the minimum: the most results per beat.
        add_row(reg_row(ROW_STEP, 32'd0));
        add_row(smp(rsg_pkg::SAMPLE_MAX, 1'b0));
        add_row(smp(rsg_pkg::SAMPLE_MIN, 1'b1));
        // Step over range clamps to the maximum.
        add_row(reg_row(ROW_STEP, 32'h1F_FFFF));
        add_row(smp(16'sd5, 1'b0));
        add_row(smp(16'sd7, 1'b1));
        // Unity step and double gain, then a step change inside the utterance.
        add_row(reg_row(ROW_STEP, 32'd65536));
        add_row(reg_row(ROW_GAIN, 32'd512));
        add_row(smp(16'sd1000, 1'b0));
        add_row(smp(-16'sd1000, 1'b0));
        add_row(smp(16'sd20000, 1'b0));
        add_row(reg_row(ROW_STEP, 32'd32768));
        add_row(smp(-16'sd20000, 1'b0));
        add_row(smp(16'sd3, 1'b1));
        // Default step with an odd gain.
        add_row(reg_row(ROW_STEP, 32'd90317));
        add_row(reg_row(ROW_GAIN, 32'd300));
        add_row(smp(rsg_pkg::SAMPLE_MIN, 1'b0));
        add_row(smp(rsg_pkg::SAMPLE_MAX, 1'b0));
        add_row(smp(-16'sd1, 1'b1));

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[k]) begin
            case (plan[k].kind)
                ROW_STEP: set_register(rsg_pkg::REG_STEP, plan[k].value);
                ROW_GAIN: set_register(rsg_pkg::REG_GAIN, plan[k].value);
                default: begin
                    b.in_sample = plan[k].value[15:0];
                    b.in_last = plan[k].last;
                    offer_sample(b, plan[k].fixed, plan[k].want);
                end
            endcase
        end

        // Random part: mostly whole utterances, some stray flags.
        while (samples_in < SAMPLE_GOAL) begin
            if (samples_in > SAMPLE_GOAL - 35) idle_on = 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 0) set_register(rsg_pkg::REG_STEP, pick_step());
                else set_register(rsg_pkg::REG_GAIN, pick_gain());
            end
            gap_odds = $urandom_range(0, 4);
            if (!hold_done && samples_in > 70) begin
                // Receiver holds off while this utterance keeps coming.
                hold_long = 1'b1;
                hold_done = 1'b1;
                gap_odds = 0;
                len = 12;
            end else begin
                len = $urandom_range(1, 10);
            end
            noise = ($urandom_range(0, 9) == 0);
            for (int n = 0; n < len; n++) begin
                b.in_sample = pick_sample();
                if (noise) b.in_last = 1'($urandom_range(0, 1));
                else b.in_last = (n == len - 1);
                offer_sample(b, 1'b0, none);
            end
        end

        s_valid <= 1'b0;
        while (due_results.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);

        $display("tb: %0d samples sent, %0d result beats checked, %0d register writes",
                 samples_in, results_checked, writes_done);
        $display("tb: steps and gains covered clamping, saturation and empty end markers");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
